[rtl/mmaf_pkg.sv]
// Shared types and constants for the maximal mask antichain filter.
`default_nettype none

package mmaf_pkg;

  localparam int DEF_TABLE_DEPTH = 64;
  localparam int DEF_MASK_WIDTH  = 64;
  localparam int IN_MASK_W       = 64;
  localparam int CNT_OUT_W       = 7;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_FINISH,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

[rtl/maximal_mask_antichain_filter.sv]
// Maximal mask antichain filter: table memory, scan sequencer and result register.
//
// Usage: masks arrive on new_mask (in_valid / in_stall). Each accepted mask
// produces exactly one result (out_valid / out_stall) carrying mask_kept,
// removed_count, entry_count and table_full. The stored masks form an
// antichain: a new mask that is covered by an entry is dropped, otherwise all
// stored strict subsets are cleared and the mask goes to the lowest free slot.
// Only the low MASK_WIDTH bits of new_mask take part.
// Timing: a nonzero mask is checked against every table entry before the next
// acceptance; the table memory is read one entry per cycle over a single read
// port. A mask that is zero after trimming skips the scan. The result register
// loads in ST_DONE (after ST_FINISH for a scan) once the output is free.
// A new mask is accepted while the previous result is still held in the
// output register; a stalled receiver holds the result, and once a second
// result is ready the block waits in its final state until the first is taken.
// Reset: rst clears the control state and then sweeps the table memory to
// zero, one entry per cycle, over every entry; in_stall stays high during
// that sweep.
`default_nettype none

module maximal_mask_antichain_filter import mmaf_pkg::*; #(
  parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
  parameter int MASK_WIDTH  = DEF_MASK_WIDTH
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [IN_MASK_W-1:0] new_mask,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 mask_kept,
  output logic [CNT_OUT_W-1:0] removed_count,
  output logic [CNT_OUT_W-1:0] entry_count,
  output logic                 table_full
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [AW-1:0] LAST_IDX = AW'(TABLE_DEPTH - 1);

  state_t state, state_next;

  logic [MASK_WIDTH-1:0] mem [TABLE_DEPTH];
  logic [MASK_WIDTH-1:0] rdata;
  logic [MASK_WIDTH-1:0] mask_reg;
  logic [AW-1:0]         rd_idx;
  logic [AW-1:0]         chk_idx;
  logic                  chk_valid;
  logic                  covered;
  logic                  free_found;
  logic [AW-1:0]         free_idx;
  logic [CW-1:0]         removed;
  logic [CW-1:0]         valid_count;
  logic [CW-1:0]         valid_count_next;

  logic                  in_zero;
  logic                  accept;
  logic                  rd_en;
  logic                  idx_adv;
  logic                  out_load;
  logic                  mem_we;
  logic [AW-1:0]         mem_waddr;
  logic [MASK_WIDTH-1:0] mem_wdata;

  logic                  e_nz;
  logic                  e_cov;
  logic                  e_sub;
  logic                  e_free;
  logic                  kept;
  logic                  full;
  logic [CW-1:0]         kept_ext;
  logic [CW+CNT_OUT_W-1:0] removed_wide;
  logic [CW+CNT_OUT_W-1:0] count_wide;

  assign in_zero = (new_mask[MASK_WIDTH-1:0] == '0);
  assign accept  = in_valid && !in_stall;

  assign e_nz   = (rdata != '0);
  assign e_cov  = e_nz && ((mask_reg & ~rdata) == '0);
  assign e_sub  = e_nz && ((rdata & ~mask_reg) == '0) && (rdata != mask_reg);
  assign e_free = !e_nz || e_sub;

  assign kept     = !covered && free_found;
  assign full     = !covered && !free_found;
  assign kept_ext = {{(CW-1){1'b0}}, kept};
  assign valid_count_next = valid_count - removed + kept_ext;

  assign removed_wide = {{CNT_OUT_W{1'b0}}, removed};
  assign count_wide   = {{CNT_OUT_W{1'b0}}, valid_count_next};

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (rd_idx == LAST_IDX) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) state_next = in_zero ? ST_DONE : ST_SCAN;
      end
      ST_SCAN: begin
        if (rd_idx == LAST_IDX) state_next = ST_FINISH;
      end
      ST_FINISH: begin
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (out_load) state_next = ST_IDLE;
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  always_comb begin
    in_stall  = 1'b1;
    rd_en     = 1'b0;
    idx_adv   = 1'b0;
    out_load  = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = rd_idx;
    mem_wdata = '0;
    unique case (state)
      ST_CLEAR: begin
        idx_adv = 1'b1;
        mem_we  = 1'b1;
      end
      ST_IDLE: begin
        in_stall = 1'b0;
      end
      ST_SCAN: begin
        rd_en     = 1'b1;
        idx_adv   = 1'b1;
        mem_we    = chk_valid && e_sub;
        mem_waddr = chk_idx;
      end
      ST_FINISH: begin
        mem_we    = chk_valid && e_sub;
        mem_waddr = chk_idx;
      end
      ST_DONE: begin
        out_load  = !out_valid || !out_stall;
        mem_we    = out_load && kept;
        mem_waddr = free_idx;
        mem_wdata = mask_reg;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (rd_en) rdata <= mem[rd_idx];
  end

  always_ff @(posedge clk) begin
    chk_idx <= rd_idx;
    if (accept) begin
      mask_reg   <= new_mask[MASK_WIDTH-1:0];
      covered    <= in_zero;
      removed    <= '0;
      free_found <= 1'b0;
    end else if (chk_valid && (state == ST_SCAN || state == ST_FINISH)) begin
      if (e_cov) covered <= 1'b1;
      if (e_sub) removed <= removed + 1'b1;
      if (e_free && !free_found) begin
        free_found <= 1'b1;
        free_idx   <= chk_idx;
      end
    end
    if (out_load) begin
      mask_kept     <= kept;
      table_full    <= full && !covered;
      removed_count <= removed_wide[CNT_OUT_W-1:0];
      entry_count   <= count_wide[CNT_OUT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_CLEAR;
      rd_idx      <= '0;
      chk_valid   <= 1'b0;
      valid_count <= '0;
      out_valid   <= 1'b0;
    end else begin
      state     <= state_next;
      chk_valid <= rd_en;
      if (idx_adv) rd_idx <= (rd_idx == LAST_IDX) ? '0 : rd_idx + 1'b1;
      if (out_load) begin
        valid_count <= valid_count_next;
        out_valid   <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_kept_full_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(mask_kept && table_full))
    else $error("mask_kept and table_full both set");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    valid_count <= CW'(TABLE_DEPTH))
    else $error("valid_count exceeds table depth");

  a_accept_start: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == ST_SCAN || state == ST_DONE))
    else $error("accepted transaction did not start processing");

  a_chk_in_scan: assert property (@(posedge clk) disable iff (rst)
    chk_valid |-> (state == ST_SCAN || state == ST_FINISH))
    else $error("read data outside scan");

  a_antichain: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE) |-> !(covered && removed != '0))
    else $error("covered mask also cleared entries");

endmodule

`default_nettype wire

[dv/tb.sv]
// Self-checking testbench for the maximal mask antichain filter.
module tb import mmaf_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int TABLE_DEPTH = DEF_TABLE_DEPTH;
  localparam int MASK_WIDTH  = DEF_MASK_WIDTH;
  localparam logic [IN_MASK_W-1:0] WIDTH_MASK = {IN_MASK_W{1'b1}} >> (IN_MASK_W - MASK_WIDTH);
  localparam int CYCLE_LIMIT = 1000000;
  localparam int HOLD_CYCLES = 6 * (TABLE_DEPTH + 3);
  localparam int DRAIN_CYCLES = TABLE_DEPTH + 16;
  localparam int EPOCH_ITEMS = 150;

  typedef struct packed {
    logic                 kept;
    logic [CNT_OUT_W-1:0] removed;
    logic [CNT_OUT_W-1:0] entries;
    logic                 full;
  } antichain_res_t;

  logic                 clk;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [IN_MASK_W-1:0] new_mask = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic                 mask_kept;
  logic [CNT_OUT_W-1:0] removed_count;
  logic [CNT_OUT_W-1:0] entry_count;
  logic                 table_full;

  logic [IN_MASK_W-1:0] stored_masks [TABLE_DEPTH];
  int                   live_count;
  antichain_res_t       expected_results [$];
  int                   errors;
  int                   cycle_count;
  int                   src_idle_pct;
  int                   sink_idle_pct;
  logic                 hold_tog = 1'b0;
  logic                 hold_seen = 1'b0;
  int                   hold_left;
  logic [IN_MASK_W-1:0] universe;

  maximal_mask_antichain_filter #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .MASK_WIDTH (MASK_WIDTH)
  ) u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .new_mask     (new_mask),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .mask_kept    (mask_kept),
    .removed_count(removed_count),
    .entry_count  (entry_count),
    .table_full   (table_full)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic antichain_res_t apply_mask(logic [IN_MASK_W-1:0] raw);
    logic [IN_MASK_W-1:0] m;
    antichain_res_t       r;
    bit                   covered;
    int                   removed;
    m = raw & WIDTH_MASK;
    r = '0;
    covered = 0;
    removed = 0;
    if (m != '0) begin
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        if (stored_masks[i] != '0 && (m & ~stored_masks[i]) == '0) covered = 1;
      end
      if (!covered) begin
        for (int i = 0; i < TABLE_DEPTH; i++) begin
          if (stored_masks[i] != '0 && (stored_masks[i] & ~m) == '0) begin
            stored_masks[i] = '0;
            removed++;
          end
        end
        live_count = (removed <= live_count) ? live_count - removed : 0;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
          if (stored_masks[i] == '0) begin
            stored_masks[i] = m;
            live_count++;
            r.kept = 1'b1;
            break;
          end
        end
        r.full = !r.kept;
      end
    end
    r.removed = removed[CNT_OUT_W-1:0];
    r.entries = live_count[CNT_OUT_W-1:0];
    return r;
  endfunction

  function automatic logic [IN_MASK_W-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [IN_MASK_W-1:0] pick_stored();
    int idx;
    if (live_count == 0) return rand64() & rand64() & rand64();
    do idx = $urandom_range(TABLE_DEPTH - 1); while (stored_masks[idx] == '0);
    return stored_masks[idx];
  endfunction

  function automatic logic [IN_MASK_W-1:0] make_universe();
    logic [IN_MASK_W-1:0] u;
    int                   nbits;
    u = '0;
    nbits = 6 + $urandom_range(4);
    repeat (nbits) u[$urandom_range(IN_MASK_W - 1)] = 1'b1;
    return u;
  endfunction

  // Masks drawn mostly from a small attribute universe that moves every epoch,
  // so subset, superset and equal relations stay frequent.
  function automatic logic [IN_MASK_W-1:0] next_random_mask();
    int pick;
    pick = $urandom_range(99);
    if (pick < 4) return '0;
    if (pick < 40) return rand64() & universe;
    if (pick < 52) return pick_stored() & rand64();
    if (pick < 60) return pick_stored();
    if (pick < 78) return pick_stored() | (rand64() & universe);
    if (pick < 83) return pick_stored() | pick_stored();
    return rand64() & rand64() & rand64();
  endfunction

  task automatic send_mask(input logic [IN_MASK_W-1:0] m);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    new_mask <= m;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    expected_results.push_back(apply_mask(m));
  endtask

  task automatic check_field(input string name, input logic [CNT_OUT_W-1:0] exp_v,
                             input logic [CNT_OUT_W-1:0] act_v);
    if (act_v !== exp_v) begin
      $display("%0t: %s expected %0d actual %0d", $time, name, exp_v, act_v);
      errors++;
    end
  endtask

  task automatic check_result();
    antichain_res_t exp_r;
    if (expected_results.size() == 0) begin
      $display("%0t: unexpected transaction kept=%0b removed=%0d entries=%0d full=%0b",
               $time, mask_kept, removed_count, entry_count, table_full);
      errors++;
    end else begin
      exp_r = expected_results.pop_front();
      check_field("mask_kept", CNT_OUT_W'(exp_r.kept), CNT_OUT_W'(mask_kept));
      check_field("removed_count", exp_r.removed, removed_count);
      check_field("entry_count", exp_r.entries, entry_count);
      check_field("table_full", CNT_OUT_W'(exp_r.full), CNT_OUT_W'(table_full));
    end
  endtask

  always @(posedge clk) begin
    if (out_valid === 1'b1 && !out_stall) check_result();
    if (hold_tog != hold_seen) begin
      hold_seen <= hold_tog;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < sink_idle_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("maximal_mask_antichain_filter: mismatch");
      $finish;
    end
  end

  task automatic test_directed();
    send_mask('0);
    send_mask(64'h1);
    send_mask(64'h1);
    send_mask(64'h3);
    send_mask(64'h2);
    send_mask(64'h1);
    send_mask(64'h8000_0000_0000_0000);
    send_mask(64'h5555_5555_5555_5555);
    send_mask(64'h5555_5555_5555_5555);
    send_mask(64'hAAAA_AAAA_AAAA_AAAA);
    send_mask(64'h0000_0000_0000_0014);
    send_mask('0);
  endtask

  // Fill with distinct adjacent bit pairs until the table overflows.
  task automatic test_full_table();
    for (int i = 1; i < IN_MASK_W - 1; i++) send_mask(64'h3 << i);
    send_mask(64'h9);
    send_mask(64'h3 << (IN_MASK_W - 2));
    send_mask(64'hE);
  endtask

  task automatic test_random(input int n);
    for (int k = 0; k < n; k++) begin
      if (k % EPOCH_ITEMS == 0) universe = make_universe();
      send_mask(next_random_mask());
    end
  endtask

  task automatic test_streaming(input int n);
    src_idle_pct = 0;
    sink_idle_pct = 0;
    for (int k = 0; k < n; k++) begin
      if (k % EPOCH_ITEMS == 0) universe = make_universe();
      send_mask(next_random_mask());
    end
    src_idle_pct = 26;
    sink_idle_pct = 26;
  endtask

  // Hold the output while masks keep coming so the block backs up.
  task automatic test_backpressure();
    src_idle_pct = 0;
    hold_tog <= ~hold_tog;
    universe = make_universe();
    repeat (24) send_mask(next_random_mask());
    src_idle_pct = 26;
  endtask

  task automatic test_clear_all();
    send_mask(64'h7FFF_FFFF_FFFF_FFFF);
    send_mask(64'hFFFF_FFFF_FFFF_FFFF);
    send_mask(64'hFFFF_FFFF_FFFF_FFFF);
    send_mask(64'h1);
    send_mask('0);
  endtask

  initial begin
    for (int i = 0; i < TABLE_DEPTH; i++) stored_masks[i] = '0;
    live_count = 0;
    src_idle_pct = 26;
    sink_idle_pct = 26;
    universe = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_full_table();
    test_random(1400);
    test_streaming(250);
    test_backpressure();
    test_random(100);
    test_clear_all();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("maximal_mask_antichain_filter: match");
    end else begin
      $display("maximal_mask_antichain_filter: mismatch");
    end
    $finish;
  end

endmodule
